// File: hw/rtl/skt_pkg.sv
// ----------------------------------------------------------------------------
// skt_pkg: shared types and constants for the sorted key table
// Item layouts, operation and status codes, and the command that the
// control logic broadcasts to the row of table cells.
// ----------------------------------------------------------------------------
package skt_pkg;

    // field widths of the item payloads
    localparam int KEY_W   = 32;
    localparam int DATA_W  = 32;
    localparam int POS_W   = 9;
    localparam int CNT_OUT_W = 9;

    // default table depth
    localparam int CAPACITY_DEF = 256;

    typedef enum logic [1:0] {
        MODE_FIND   = 2'd0,
        MODE_INSERT = 2'd1,
        MODE_DELETE = 2'd2,
        MODE_CLEAR  = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        STAT_OK       = 2'd0,
        STAT_FULL     = 2'd1,
        STAT_NO_ENTRY = 2'd2
    } t_status;

    typedef struct packed {
        t_mode               mode;
        logic [KEY_W-1:0]    key;
        logic [DATA_W-1:0]   entry_data;
    } t_in_item;

    typedef struct packed {
        logic                found;
        logic [POS_W-1:0]    position;
        logic [CNT_OUT_W-1:0] count;
        t_status             status;
        logic [DATA_W-1:0]   read_data;
    } t_out_item;

    // what every cell does in the commit cycle
    typedef enum logic [1:0] {
        OP_HOLD      = 2'd0,
        OP_OVERWRITE = 2'd1,
        OP_INSERT    = 2'd2,
        OP_REMOVE    = 2'd3
    } t_cell_op;

    typedef struct packed {
        t_cell_op            op;
        logic [KEY_W-1:0]    key;
        logic [DATA_W-1:0]   data;
    } t_cell_cmd;

    typedef enum logic {
        ST_IDLE   = 1'b0,
        ST_COMMIT = 1'b1
    } t_state;

endpackage

// File: hw/rtl/skt_cell.sv
// ----------------------------------------------------------------------------
// skt_cell: one entry of the sorted key table
// Holds a key and its payload, compares against the broadcast key, flags
// the insertion point, and shifts to or from its neighbors on command.
// ----------------------------------------------------------------------------
module skt_cell #(
    parameter int CNT_W = 9,
    parameter int IDX   = 0
) (
    input  logic                          i_clk,
    input  logic                          i_capture,
    input  logic [skt_pkg::KEY_W-1:0]     i_key,
    input  logic [CNT_W-1:0]              i_count,
    input  logic [CNT_W-1:0]              i_pos,
    input  logic                          i_left_lt,
    output logic                          o_lt,
    input  skt_pkg::t_cell_cmd            i_cmd,
    input  logic [skt_pkg::KEY_W-1:0]     i_left_key,
    input  logic [skt_pkg::DATA_W-1:0]    i_left_data,
    input  logic [skt_pkg::KEY_W-1:0]     i_right_key,
    input  logic [skt_pkg::DATA_W-1:0]    i_right_data,
    output logic [skt_pkg::KEY_W-1:0]     o_key,
    output logic [skt_pkg::DATA_W-1:0]    o_data,
    output logic                          o_ins,
    output logic                          o_hit,
    output logic [skt_pkg::DATA_W-1:0]    o_rd_data
);

    localparam logic [CNT_W-1:0] IDX_C = CNT_W'(IDX);

    logic [skt_pkg::KEY_W-1:0]  r_key;
    logic [skt_pkg::DATA_W-1:0] r_data;
    logic                       r_ins;
    logic                       r_hit;
    logic                       r_up;
    logic                       r_ge;
    logic                       w_valid;
    logic                       w_eq;

    // compare against the search key, only for occupied entries
    assign w_valid = (IDX_C < i_count);
    assign o_lt    = w_valid && (r_key < i_key);
    assign w_eq    = w_valid && (r_key == i_key);

    // decision flags taken when an item is accepted
    always_ff @(posedge i_clk) begin
        if (i_capture) begin
            r_ins <= i_left_lt && !o_lt;
            r_hit <= i_left_lt && !o_lt && w_eq;
            r_up  <= !i_left_lt;
            r_ge  <= (IDX_C >= i_pos);
        end
    end

    // entry update in the commit cycle
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            skt_pkg::OP_OVERWRITE: begin
                if (r_hit) begin
                    r_data <= i_cmd.data;
                end
            end
            skt_pkg::OP_INSERT: begin
                if (r_ins) begin
                    r_key  <= i_cmd.key;
                    r_data <= i_cmd.data;
                end else if (r_up) begin
                    r_key  <= i_left_key;
                    r_data <= i_left_data;
                end
            end
            skt_pkg::OP_REMOVE: begin
                if (r_ge) begin
                    r_key  <= i_right_key;
                    r_data <= i_right_data;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_key     = r_key;
    assign o_data    = r_data;
    assign o_ins     = r_ins;
    assign o_hit     = r_hit;
    assign o_rd_data = r_hit ? r_data : '0;

endmodule

// File: hw/rtl/sorted_key_table_unit.sv
// ----------------------------------------------------------------------------
// sorted_key_table_unit: sorted key table built from a row of entry cells
// Keeps up to CAPACITY key and payload entries in ascending key order with
// a count and a current position; find, insert, delete and clear items.
// ----------------------------------------------------------------------------
// Usage:
//   input channel i_in_valid / o_in_stall / i_in_item carries one operation;
//   output channel o_out_valid / i_out_stall / o_out_item returns exactly one
//   result item for each operation, in order.
//   For each item, at the accepting edge every cell compares its
//   key with the item key in parallel and latches its decision flags; in the
//   next cycle the cells shift or write and the result is registered. The
//   next item is taken only after that commit, while no stalled result is held.
//   o_out_valid rises together with the registered result.
//   The output register frees the input side: a new item is taken while a
//   result waits, as long as that result is being taken in the same cycle.
//   While i_out_stall holds a result, o_in_stall stays high.
//   Reset (i_rst_n low, synchronous) empties the table and sets the position
//   to zero; entry contents are not cleared, as only occupied entries are read.
// ----------------------------------------------------------------------------
module sorted_key_table_unit #(
    parameter int CAPACITY = skt_pkg::CAPACITY_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  skt_pkg::t_in_item i_in_item,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output skt_pkg::t_out_item o_out_item
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam logic [CNT_W-1:0] CAP_C = CNT_W'(CAPACITY);

    skt_pkg::t_state            r_state;
    skt_pkg::t_state            n_state;
    logic [CNT_W-1:0]           r_count;
    logic [CNT_W-1:0]           n_count;
    logic [CNT_W-1:0]           r_pos;
    logic [CNT_W-1:0]           n_pos;
    skt_pkg::t_mode             r_mode;
    logic [skt_pkg::KEY_W-1:0]  r_key;
    logic [skt_pkg::DATA_W-1:0] r_data;
    logic                       r_all_lt;
    logic                       r_out_valid;
    skt_pkg::t_out_item         r_out_item;
    skt_pkg::t_out_item         n_out_item;
    skt_pkg::t_cell_cmd         w_cmd;

    logic                       w_accept;
    logic                       w_commit;
    logic                       w_out_take;

    logic [CAPACITY:0]          w_lt_chain;
    logic [skt_pkg::KEY_W-1:0]  w_key_ext  [0:CAPACITY+1];
    logic [skt_pkg::DATA_W-1:0] w_data_ext [0:CAPACITY+1];
    logic [CAPACITY-1:0]        w_ins;
    logic [CAPACITY-1:0]        w_hit;
    logic [skt_pkg::DATA_W-1:0] w_rd [0:CAPACITY-1];

    logic                       w_any_hit;
    logic [CNT_W-1:0]           w_ins_pos;
    logic [skt_pkg::DATA_W-1:0] w_hit_data;

    // handshake
    assign w_out_take  = r_out_valid && !i_out_stall;
    assign w_accept    = i_in_valid && !o_in_stall;
    assign w_commit    = (r_state == skt_pkg::ST_COMMIT);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    // row of cells; the left end sees an always-below key on its left
    assign w_lt_chain[0]           = 1'b1;
    assign w_key_ext[0]            = '0;
    assign w_data_ext[0]           = '0;
    assign w_key_ext[CAPACITY+1]   = '0;
    assign w_data_ext[CAPACITY+1]  = '0;

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
            skt_cell #(
                .CNT_W (CNT_W),
                .IDX   (gi)
            ) u_cell (
                .i_clk        (i_clk),
                .i_capture    (w_accept),
                .i_key        (i_in_item.key),
                .i_count      (r_count),
                .i_pos        (r_pos),
                .i_left_lt    (w_lt_chain[gi]),
                .o_lt         (w_lt_chain[gi+1]),
                .i_cmd        (w_cmd),
                .i_left_key   (w_key_ext[gi]),
                .i_left_data  (w_data_ext[gi]),
                .i_right_key  (w_key_ext[gi+2]),
                .i_right_data (w_data_ext[gi+2]),
                .o_key        (w_key_ext[gi+1]),
                .o_data       (w_data_ext[gi+1]),
                .o_ins        (w_ins[gi]),
                .o_hit        (w_hit[gi]),
                .o_rd_data    (w_rd[gi])
            );
        end
    endgenerate

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            skt_pkg::ST_IDLE: begin
                if (w_accept) begin
                    n_state = skt_pkg::ST_COMMIT;
                end
            end
            skt_pkg::ST_COMMIT: begin
                n_state = skt_pkg::ST_IDLE;
            end
            default: begin
                n_state = skt_pkg::ST_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb begin
        case (r_state)
            skt_pkg::ST_IDLE: o_in_stall = r_out_valid && i_out_stall;
            default:          o_in_stall = 1'b1;
        endcase
    end

    // insertion point, hit and read payload collected from the row
    always_comb begin
        w_ins_pos  = r_all_lt ? CAP_C : '0;
        w_hit_data = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            if (w_ins[i]) begin
                w_ins_pos = w_ins_pos | CNT_W'(i);
            end
            w_hit_data = w_hit_data | w_rd[i];
        end
        w_any_hit = |w_hit;
    end

    // commit decision
    always_comb begin
        n_count    = r_count;
        n_pos      = r_pos;
        w_cmd.op   = skt_pkg::OP_HOLD;
        w_cmd.key  = r_key;
        w_cmd.data = r_data;
        n_out_item.found     = 1'b0;
        n_out_item.status    = skt_pkg::STAT_OK;
        n_out_item.read_data = '0;
        if (w_commit) begin
            case (r_mode)
                skt_pkg::MODE_FIND: begin
                    n_pos = w_ins_pos;
                    if (w_any_hit) begin
                        n_out_item.found     = 1'b1;
                        n_out_item.read_data = w_hit_data;
                    end
                end
                skt_pkg::MODE_INSERT: begin
                    n_pos = w_ins_pos;
                    if (w_any_hit) begin
                        w_cmd.op             = skt_pkg::OP_OVERWRITE;
                        n_out_item.found     = 1'b1;
                        n_out_item.read_data = r_data;
                    end else if (r_count == CAP_C) begin
                        n_out_item.status = skt_pkg::STAT_FULL;
                    end else begin
                        w_cmd.op = skt_pkg::OP_INSERT;
                        n_count  = CNT_W'(r_count + 1'b1);
                    end
                end
                skt_pkg::MODE_DELETE: begin
                    if (r_pos < r_count) begin
                        w_cmd.op = skt_pkg::OP_REMOVE;
                        n_count  = CNT_W'(r_count - 1'b1);
                    end else begin
                        n_out_item.status = skt_pkg::STAT_NO_ENTRY;
                    end
                end
                default: begin
                    n_count = '0;
                    n_pos   = '0;
                end
            endcase
        end
        n_out_item.position = skt_pkg::POS_W'(n_pos);
        n_out_item.count    = skt_pkg::CNT_OUT_W'(n_count);
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= skt_pkg::ST_IDLE;
            r_count     <= '0;
            r_pos       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_pos   <= n_pos;
            if (w_commit) begin
                r_out_valid <= 1'b1;
            end else if (w_out_take) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // item capture and result register
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_mode   <= i_in_item.mode;
            r_key    <= i_in_item.key;
            r_data   <= i_in_item.entry_data;
            r_all_lt <= w_lt_chain[CAPACITY];
        end
        if (w_commit) begin
            r_out_item <= n_out_item;
        end
    end

endmodule
